// File: rtl/core/hej_pkg.sv
// ----------------------------------------------------------------------------
// hej_pkg
// Shared types and constants of the hash equi-join engine.
// ----------------------------------------------------------------------------
package hej_pkg;

    localparam int KEY_W  = 64;
    localparam int DATA_W = 64;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_PROBE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_INT64  = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_STRING = 2'd2,
        KIND_DATE32 = 2'd3
    } t_kind;

    localparam logic [0:0] CFG_BUILD_KIND = 1'b0;
    localparam logic [0:0] CFG_PROBE_KIND = 1'b1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  key_bits;
        logic [DATA_W-1:0] row_payload;
    } t_in_beat;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] probe_payload;
        logic [DATA_W-1:0] build_payload;
        logic              last;
    } t_out_beat;

    function automatic logic f_is_nan(input logic [KEY_W-1:0] b);
        return (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    endfunction

    function automatic logic f_key_eq(input logic [1:0] kind,
                                      input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
        logic r;
        r = 1'b0;
        case (kind)
            KIND_INT64:  r = (a == b);
            KIND_DOUBLE: r = !f_is_nan(a) && !f_is_nan(b) &&
                             (((a[62:0] | b[62:0]) == 63'd0) || (a == b));
            default:     r = (a[31:0] == b[31:0]);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/hej_stream_if.sv
// ----------------------------------------------------------------------------
// hej_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hej_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/hej_front.sv
// ----------------------------------------------------------------------------
// hej_front
// Accepts input beats, masks the payload, drops mode 3 and queues the rest.
// ----------------------------------------------------------------------------
module hej_front import hej_pkg::*; #(
    parameter int PAYLOAD_WIDTH = 64,
    parameter int QDEPTH        = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hej_stream_if.sink s_in,
    output logic       o_q_valid,
    output t_in_beat   o_q_data,
    input  logic       i_q_pop
);
    localparam int AW = $clog2(QDEPTH);

    t_in_beat        r_q [QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            w_push;
    t_in_beat        w_beat;

    assign s_in.ready = (r_cnt != (AW+1)'(QDEPTH));

    always_comb begin
        w_beat = s_in.data;
        w_beat.row_payload = DATA_W'(s_in.data.row_payload[PAYLOAD_WIDTH-1:0]);
    end

    assign w_push   = s_in.valid && s_in.ready && (s_in.data.mode != MODE_NONE);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_beat;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_q_pop) r_rp <= (r_rp == AW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(i_q_pop);
        end
    end

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop on empty queue");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QDEPTH)) else $error("queue overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(QDEPTH)) |-> !s_in.ready) else $error("ready when full");
endmodule

// File: rtl/core/hej_back.sv
// ----------------------------------------------------------------------------
// hej_back
// Executes clear/build/probe against the row table; probe scans one row
// per cycle through a registered memory read, unless a held match waits on the output.
// ----------------------------------------------------------------------------
module hej_back import hej_pkg::*; #(
    parameter int TABLE_ROWS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_in_beat     i_q_data,
    output logic         o_q_pop,
    input  logic [1:0]   i_build_kind,
    input  logic [1:0]   i_probe_kind,
    hej_stream_if.source m_out
);
    localparam int AW = $clog2(TABLE_ROWS);
    localparam int CW = $clog2(TABLE_ROWS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} t_state;

    logic [KEY_W-1:0]  r_key_mem [TABLE_ROWS];
    logic [DATA_W-1:0] r_pay_mem [TABLE_ROWS];

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_idx;
    logic              r_rd_v;
    logic [KEY_W-1:0]  r_rd_key;
    logic [DATA_W-1:0] r_rd_pay;
    logic [KEY_W-1:0]  r_pkey;
    logic [DATA_W-1:0] r_ppay;
    logic              r_hv;
    logic [DATA_W-1:0] r_held;
    logic              r_ov;
    t_out_beat         r_out;

    logic              w_match, w_emit, w_ofree, w_kinds;
    logic              w_adv;

    assign w_kinds = (i_build_kind == i_probe_kind);
    assign w_match = r_rd_v && f_key_eq(i_probe_kind, r_pkey, r_rd_key);
    assign w_ofree = !r_ov || m_out.ready;
    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
    assign w_emit  = r_hv && w_ofree &&
                     (w_match || (r_state == S_DRAIN && !r_rd_v));
    // scan may advance when held slot free or being emitted, or when there is no new match
    assign w_adv = !(r_hv && w_match && !w_emit);

    always_comb begin
        o_q_pop = 1'b0;
        if (r_state == S_IDLE && i_q_valid) begin
            case (i_q_data.mode)
                MODE_BUILD: o_q_pop = (r_cnt < CW'(TABLE_ROWS)) || w_ofree;
                default:    o_q_pop = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_q_pop && i_q_data.mode == MODE_BUILD &&
            r_cnt < CW'(TABLE_ROWS)) begin
            r_key_mem[r_cnt[AW-1:0]] <= i_q_data.key_bits;
            r_pay_mem[r_cnt[AW-1:0]] <= i_q_data.row_payload;
        end
        if (w_adv && r_idx < r_cnt) begin
            r_rd_key <= r_key_mem[r_idx[AW-1:0]];
            r_rd_pay <= r_pay_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && m_out.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        case (i_q_data.mode)
                            MODE_CLEAR: r_cnt <= '0;
                            MODE_BUILD: begin
                                if (r_cnt < CW'(TABLE_ROWS)) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end else begin
                                    r_ov  <= 1'b1;
                                    r_out <= '{status: 1'b1, probe_payload: '0,
                                               build_payload: i_q_data.row_payload,
                                               last: 1'b1};
                                end
                            end
                            MODE_PROBE: begin
                                if (w_kinds && r_cnt != '0) begin
                                    r_state <= S_SCAN;
                                    r_idx   <= '0;
                                    r_rd_v  <= 1'b0;
                                    r_pkey  <= i_q_data.key_bits;
                                    r_ppay  <= i_q_data.row_payload;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN, S_DRAIN: begin
                    if (w_emit) begin
                        r_ov  <= 1'b1;
                        r_out <= '{status: 1'b0, probe_payload: r_ppay,
                                   build_payload: r_held,
                                   last: (r_state == S_DRAIN && !r_rd_v)};
                        r_hv  <= 1'b0;
                    end
                    if (w_adv) begin
                        if (w_match) begin
                            r_hv   <= 1'b1;
                            r_held <= r_rd_pay;
                        end
                        r_rd_v <= (r_idx < r_cnt);
                        if (r_idx < r_cnt) r_idx <= r_idx + 1'b1;
                        else r_state <= S_DRAIN;
                    end
                    if (r_state == S_DRAIN && !r_rd_v && (!r_hv || w_emit)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |=> (r_ov && $stable(r_out))) else $error("out lost");
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_ROWS)) else $error("count overflow");
    a_idle_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE)) else $error("pop while busy");
endmodule

// File: rtl/core/hash_equi_join.sv
// ----------------------------------------------------------------------------
// hash_equi_join
// Single-column equi-join engine: build table of rows, probe by key.
// ----------------------------------------------------------------------------
// Input beats (s_in) carry mode, key_bits and row_payload. Clear empties the
// table, build appends a row, probe scans all stored rows in insertion order
// and emits one beat on m_out per key match, last set on the final one. A
// build into a full table emits one status beat. Mode 3 is dropped.
// Build and clear are handled in the back end directly; a probe is paced by
// the one-row-per-cycle scan of the row memory. A two-entry queue sits
// between front and back, so input is taken while a probe scans. Output is
// registered; a stalled receiver stalls the scan and, once the queue fills,
// the input. Reset (i_rst_n low, synchronous) empties the table and queue
// and sets both key kinds to int64. Key kinds are set through the write port;
// the user must write them only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module hash_equi_join import hej_pkg::*; #(
    parameter int TABLE_ROWS    = 64,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [1:0]   i_cfg_data,
    hej_stream_if.sink   s_in,
    hej_stream_if.source m_out
);
    logic [1:0] r_build_kind, r_probe_kind;
    logic       w_q_valid, w_q_pop;
    t_in_beat   w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build_kind <= KIND_INT64;
            r_probe_kind <= KIND_INT64;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BUILD_KIND) r_build_kind <= i_cfg_data;
            else r_probe_kind <= i_cfg_data;
        end
    end

    hej_front #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH), .QDEPTH(2)) u_front (
        .i_clk, .i_rst_n, .s_in,
        .o_q_valid(w_q_valid), .o_q_data(w_q_data), .i_q_pop(w_q_pop)
    );

    hej_back #(.TABLE_ROWS(TABLE_ROWS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .i_q_data(w_q_data), .o_q_pop(w_q_pop),
        .i_build_kind(r_build_kind), .i_probe_kind(r_probe_kind), .m_out
    );
endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hash_equi_join: builds, probes, clears and
// overflows the row table under several key-kind settings and random
// sender/receiver gaps, checking every output beat against a local model.
// ----------------------------------------------------------------------------
module tb;
    import hej_pkg::*;

    localparam int ROWS = 64;

    class join_scoreboard;
        t_kind     build_kind, probe_kind;
        int        row_cnt;
        logic [63:0] row_key [ROWS];
        logic [63:0] row_pay [ROWS];
        t_out_beat pending_pairs[$];
        int        errors;
        int        beats_seen;

        function new();
            build_kind = KIND_INT64;
            probe_kind = KIND_INT64;
            row_cnt = 0;
            errors = 0;
            beats_seen = 0;
        endfunction

        function bit key_match(t_kind k, logic [63:0] a, logic [63:0] b);
            bit nan_a, nan_b;
            nan_a = (a[62:52] == 11'h7ff) && (a[51:0] != 0);
            nan_b = (b[62:52] == 11'h7ff) && (b[51:0] != 0);
            case (k)
                KIND_INT64:  return a == b;
                KIND_DOUBLE: begin
                    if (nan_a || nan_b) return 0;
                    if ((a[62:0] | b[62:0]) == 63'd0) return 1;
                    return a == b;
                end
                default:     return a[31:0] == b[31:0];
            endcase
        endfunction

        function void expect_beat(t_out_beat o);
            pending_pairs.insert(pending_pairs.size(), o);
        endfunction

        function void note_input(t_in_beat b);
            t_out_beat o;
            int n;
            n = 0;
            case (t_mode'(b.mode))
                MODE_CLEAR: row_cnt = 0;
                MODE_BUILD: begin
                    if (row_cnt >= ROWS) begin
                        o.status = 1; o.probe_payload = 0;
                        o.build_payload = b.row_payload; o.last = 1;
                        expect_beat(o);
                    end else begin
                        row_key[row_cnt] = b.key_bits;
                        row_pay[row_cnt] = b.row_payload;
                        row_cnt++;
                    end
                end
                MODE_PROBE: begin
                    if (build_kind == probe_kind) begin
                        for (int i = 0; i < row_cnt; i++) begin
                            if (key_match(probe_kind, b.key_bits, row_key[i])) begin
                                o.status = 0; o.probe_payload = b.row_payload;
                                o.build_payload = row_pay[i]; o.last = 0;
                                expect_beat(o);
                                n++;
                            end
                        end
                        if (n > 0) pending_pairs[$].last = 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat exp;
            beats_seen++;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
                return;
            end
            exp = pending_pairs.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.probe_payload !== exp.probe_payload) begin
                $display("%0t: probe_payload exp %h got %h", $time,
                         exp.probe_payload, got.probe_payload);
                errors++;
            end
            if (got.build_payload !== exp.build_payload) begin
                $display("%0t: build_payload exp %h got %h", $time,
                         exp.build_payload, got.build_payload);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we, i_cfg_idx;
    logic [1:0] i_cfg_data;
    hej_stream_if #(.T(t_in_beat))  in_ch ();
    hej_stream_if #(.T(t_out_beat)) out_ch ();

    hash_equi_join dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    join_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    bit  hold_off;
    longint cycles;
    int  items_sent;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver side
    initial begin
        out_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_beat(out_ch.data);
            if (hold_off) out_ch.ready <= 0;
            else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(t_mode m, logic [63:0] k, logic [63:0] p);
        t_in_beat b;
        b.mode = m; b.key_bits = k; b.row_payload = p;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(b);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (4 * (ROWS + 10)) @(posedge i_clk);
    endtask

    task automatic set_kinds(t_kind bk, t_kind pk);
        drain();
        i_cfg_we <= 1; i_cfg_idx <= CFG_BUILD_KIND; i_cfg_data <= bk;
        @(posedge i_clk);
        i_cfg_idx <= CFG_PROBE_KIND; i_cfg_data <= pk;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.build_kind = bk;
        sb.probe_kind = pk;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pool_key(t_kind k);
        logic [63:0] v;
        case ($urandom_range(7))
            0: v = 64'h0;
            1: v = 64'h8000_0000_0000_0000;
            2: v = 64'h7ff8_0000_0000_0001;
            3: v = {$urandom, 32'd0} | $urandom_range(3);
            default: v = $urandom_range(5);
        endcase
        if (k >= KIND_STRING && $urandom_range(1)) v[63:32] = $urandom;
        return v;
    endfunction

    task automatic random_phase(int n, t_kind k);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 3) send_beat(MODE_CLEAR, rand64(), rand64());
            else if (r < 5) send_beat(MODE_NONE, rand64(), rand64());
            else if (r < 45) send_beat(MODE_BUILD, pool_key(k), rand64());
            else if (r < 95) send_beat(MODE_PROBE, pool_key(k), rand64());
            else send_beat(MODE_PROBE, rand64(), rand64());
        end
    endtask

    initial begin
        sb = new();
        hold_off = 0;
        items_sent = 0;
        send_idle_pct = 24; recv_idle_pct = 46;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        in_ch.valid = 0; in_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, duplicates, no match, ignored mode
        send_beat(MODE_BUILD, 64'h0, 64'h0);
        send_beat(MODE_BUILD, '1, '1);
        send_beat(MODE_BUILD, 64'h0, 64'h1234);
        send_beat(MODE_PROBE, 64'h0, 64'hAAAA_5555_AAAA_5555);
        send_beat(MODE_PROBE, '1, 64'h5555_AAAA_5555_AAAA);
        send_beat(MODE_PROBE, 64'h8000_0000_0000_0000, '1);
        send_beat(MODE_NONE, 64'h0, 64'h1);
        send_beat(MODE_PROBE, 64'h0, '0);
        // doubles: signed zero equal, NaN never
        set_kinds(KIND_DOUBLE, KIND_DOUBLE);
        send_beat(MODE_BUILD, 64'h7ff8_0000_0000_0000, 64'h77);
        send_beat(MODE_PROBE, 64'h8000_0000_0000_0000, 64'h99);
        send_beat(MODE_PROBE, 64'h7ff8_0000_0000_0000, 64'h98);
        send_beat(MODE_PROBE, 64'h7ff0_0000_0000_0000, 64'h97);
        // kinds differ: nothing
        set_kinds(KIND_STRING, KIND_DATE32);
        send_beat(MODE_PROBE, 64'h0, 64'h1);
        set_kinds(KIND_DATE32, KIND_DATE32);
        send_beat(MODE_PROBE, 64'hFFFF_FFFF_0000_0000, 64'h2);
        send_beat(MODE_CLEAR, '0, '0);
        // fill to overflow, then a full-table probe under back-pressure
        for (int i = 0; i < ROWS + 2; i++) send_beat(MODE_BUILD, 64'h5, rand64());
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 4; i++) send_beat(MODE_PROBE, 64'h5, rand64());
        join
        send_beat(MODE_CLEAR, '0, '0);

        set_kinds(KIND_INT64, KIND_INT64);
        random_phase(110, KIND_INT64);
        send_idle_pct = 46; recv_idle_pct = 24;
        set_kinds(KIND_DOUBLE, KIND_DOUBLE);
        random_phase(110, KIND_DOUBLE);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_kinds(KIND_STRING, KIND_STRING);
        random_phase(60, KIND_STRING);
        set_kinds(KIND_DATE32, KIND_INT64);
        random_phase(20, KIND_DATE32);
        set_kinds(KIND_DATE32, KIND_DATE32);
        random_phase(40, KIND_DATE32);
        drain();

        $display("Sent %0d input beats over four key kinds; checked %0d output beats.",
                 items_sent, sb.beats_seen);
        if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
